@@ hdl/bpe_pkg.sv @@
// Shared types and constants for the Bezier point evaluator.
// No dependencies; every other file in the block imports this package.
package bpe_pkg;

	// Coordinate and parameter formats
	localparam int COORD_W   = 16;          // signed Q8.8
	localparam int NUM_AXES  = 3;           // x, y, z
	localparam int NUM_PTS   = 4;           // control point registers
	localparam int MAX_DEGREE = 3;
	localparam int FRAC_W    = 16;          // t is Q1.16
	localparam int T_W       = FRAC_W + 1;  // 0 .. 1.0 inclusive
	localparam int PROD_W    = (COORD_W + 1) + (T_W + 1);
	localparam int QUO_W     = PROD_W - FRAC_W;
	localparam int SUM_W     = QUO_W + 1;
	localparam int ROUND_HALF = 1 << (FRAC_W - 1);

	// Configuration port
	localparam int CFG_W     = NUM_AXES * COORD_W;
	localparam int CFG_IDX_W = 3;
	localparam int DEG_W     = 2;
	localparam int DEGREE_RESET = 3;

	// Pipeline depth: input, three levels of (multiply, round/add)
	localparam int NUM_STAGES = 7;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [T_W-1:0]            param_t;
	typedef logic [CFG_W-1:0]          cpoint_t;
	typedef logic [DEG_W-1:0]          degree_t;

	localparam param_t T_ONE     = param_t'(1 << FRAC_W);
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE = 3'd0,
		REG_CP0    = 3'd1,
		REG_CP1    = 3'd2,
		REG_CP2    = 3'd3,
		REG_CP3    = 3'd4
	} cfg_reg_t;

	// Stage load enables and valid bits from the flow control
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] vld;
	} flow_t;

endpackage

@@ hdl/bpe_param_if.sv @@
// Input channel: one curve parameter per beat.
// Depends on bpe_pkg.
interface bpe_param_if import bpe_pkg::*; ();
	logic   valid;
	logic   ready;
	param_t curve_param;

	modport source (output valid, output curve_param, input ready);
	modport sink   (input valid, input curve_param, output ready);
endinterface

@@ hdl/bpe_point_if.sv @@
// Output channel: one curve point (x, y, z) per beat.
// Depends on bpe_pkg.
interface bpe_point_if import bpe_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

@@ hdl/bpe_lerp_mul.sv @@
// First half of one interpolation step: t * (q - p).
// Depends on bpe_pkg.
module bpe_lerp_mul import bpe_pkg::*; (
	input  coord_t p,
	input  coord_t q,
	input  param_t t,
	output prod_t  prod
);

	logic signed [COORD_W:0] diff;
	prod_t diff_x;
	prod_t t_x;

	// difference needs one extra bit; t is zero-extended to stay positive
	always_comb begin
		diff   = {q[COORD_W-1], q} - {p[COORD_W-1], p};
		diff_x = {{(PROD_W-COORD_W-1){diff[COORD_W]}}, diff};
		t_x    = {{(PROD_W-T_W){1'b0}}, t};
		prod   = diff_x * t_x;
	end

endmodule

@@ hdl/bpe_lerp_fin.sv @@
// Second half of one interpolation step: round to nearest (ties up),
// add the base point and saturate. Depends on bpe_pkg.
module bpe_lerp_fin import bpe_pkg::*; (
	input  coord_t p,
	input  prod_t  prod,
	output coord_t r
);

	prod_t                 rnd;
	logic [QUO_W-1:0]      quo;
	logic [SUM_W-1:0]      sum;
	logic [SUM_W-COORD_W:0] top;

	always_comb begin
		// floor((prod + half) / 2^FRAC_W) is an arithmetic shift
		rnd = prod + PROD_W'(ROUND_HALF);
		quo = rnd[PROD_W-1:FRAC_W];
		sum = {{(SUM_W-COORD_W){p[COORD_W-1]}}, p} + {quo[QUO_W-1], quo};
		top = sum[SUM_W-1:COORD_W-1];
		// clamp when the upper bits are not a plain sign extension
		if ((&top) || (~|top)) begin
			r = sum[COORD_W-1:0];
		end else if (sum[SUM_W-1]) begin
			r = COORD_MIN;
		end else begin
			r = COORD_MAX;
		end
	end

endmodule

@@ hdl/bpe_flow.sv @@
// Valid bits and per-stage load enables for the evaluation pipeline.
// Bubbles collapse; a stage loads when empty or when its successor loads.
// Depends on bpe_pkg.
module bpe_flow import bpe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_ready,
	output flow_t flow
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] load;

	// load chain from the output end back to the input
	always_comb begin
		load[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			load[k] = !vld_q[k] || load[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (load[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign flow.load = load;
	assign flow.vld  = vld_q;

endmodule

@@ hdl/bezier_point_evaluator_unit.sv @@
// Bezier point evaluator: De Casteljau evaluation of a 3-D curve of degree
// up to three. Depends on bpe_pkg, bpe_param_if, bpe_point_if, bpe_flow,
// bpe_lerp_mul and bpe_lerp_fin.
//
// Usage:
//   Write the degree and control points through the wr_en / wr_index /
//   wr_data port while no beat is in flight. Then stream curve parameters
//   (Q1.16, values above 1.0 clamp to 1.0) on the param channel; one point
//   (x, y, z in signed Q8.8) comes back on the point channel per beat,
//   in order.
//   Each accepted param beat passes through every stage to its point beat.
//   One beat is taken per cycle unless the receiver stalls; there are
//   seven register stages (input, then a multiply stage and a round/add
//   stage for each of the three interpolation levels), each holding a
//   full level of lanes, so nothing is shared between beats.
//   When the receiver stalls, the output stage holds its point and the
//   stages behind it keep filling any empty slots; param.ready drops only
//   once every stage is occupied.
//   Reset clears all valid bits, sets the degree to three and the control
//   points to zero.
module bezier_point_evaluator_unit import bpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	bpe_param_if.sink        param,
	bpe_point_if.source      point
);

	// configuration registers
	degree_t deg_q;
	cpoint_t cp_q [NUM_PTS];

	flow_t   flow;
	degree_t eff_deg;
	coord_t  cp [NUM_PTS][NUM_AXES];

	// pipeline payload
	param_t t_s1, t_s2, t_s3, t_s4, t_s5;
	prod_t  prod_s2 [3][NUM_AXES];
	coord_t base_s2 [3][NUM_AXES];
	coord_t lvl1_s3 [3][NUM_AXES];
	prod_t  prod_s4 [2][NUM_AXES];
	coord_t base_s4 [2][NUM_AXES];
	coord_t lvl1_s4 [NUM_AXES];
	coord_t lvl2_s5 [2][NUM_AXES];
	coord_t lvl1_s5 [NUM_AXES];
	prod_t  prod_s6 [NUM_AXES];
	coord_t base_s6 [NUM_AXES];
	coord_t lvl1_s6 [NUM_AXES];
	coord_t lvl2_s6 [NUM_AXES];
	coord_t res_s7  [NUM_AXES];

	// combinational lane outputs
	prod_t  prod1 [3][NUM_AXES];
	coord_t lvl1  [3][NUM_AXES];
	prod_t  prod2 [2][NUM_AXES];
	coord_t lvl2  [2][NUM_AXES];
	prod_t  prod3 [NUM_AXES];
	coord_t lvl3  [NUM_AXES];
	coord_t res   [NUM_AXES];

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= DEG_W'(DEGREE_RESET);
			for (int i = 0; i < NUM_PTS; i++) begin
				cp_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_DEGREE: deg_q   <= wr_data[DEG_W-1:0];
				REG_CP0:    cp_q[0] <= wr_data;
				REG_CP1:    cp_q[1] <= wr_data;
				REG_CP2:    cp_q[2] <= wr_data;
				REG_CP3:    cp_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	// unpack control points, x in the low bits
	always_comb begin
		for (int i = 0; i < NUM_PTS; i++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				cp[i][a] = cp_q[i][a*COORD_W +: COORD_W];
			end
		end
		eff_deg = (deg_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_q;
	end

	bpe_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (param.valid),
		.out_ready (point.ready),
		.flow      (flow)
	);

	assign param.ready = flow.load[0];

	// interpolation lanes
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		for (genvar j = 0; j < 3; j++) begin : g_l1
			bpe_lerp_mul u_mul (
				.p (cp[j][a]), .q (cp[j+1][a]), .t (t_s1), .prod (prod1[j][a])
			);
			bpe_lerp_fin u_fin (
				.p (base_s2[j][a]), .prod (prod_s2[j][a]), .r (lvl1[j][a])
			);
		end
		for (genvar j = 0; j < 2; j++) begin : g_l2
			bpe_lerp_mul u_mul (
				.p (lvl1_s3[j][a]), .q (lvl1_s3[j+1][a]), .t (t_s3), .prod (prod2[j][a])
			);
			bpe_lerp_fin u_fin (
				.p (base_s4[j][a]), .prod (prod_s4[j][a]), .r (lvl2[j][a])
			);
		end
		bpe_lerp_mul u_mul3 (
			.p (lvl2_s5[0][a]), .q (lvl2_s5[1][a]), .t (t_s5), .prod (prod3[a])
		);
		bpe_lerp_fin u_fin3 (
			.p (base_s6[a]), .prod (prod_s6[a]), .r (lvl3[a])
		);
	end

	// pick the level that matches the degree
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			unique case (eff_deg)
				2'd0:    res[a] = cp[0][a];
				2'd1:    res[a] = lvl1_s6[a];
				2'd2:    res[a] = lvl2_s6[a];
				default: res[a] = lvl3[a];
			endcase
		end
	end

	// stage 1: input register, t clamped to 1.0
	always_ff @(posedge clk) begin
		if (flow.load[0]) begin
			t_s1 <= (param.curve_param > T_ONE) ? T_ONE : param.curve_param;
		end
	end

	// stage 2: level 1 products
	always_ff @(posedge clk) begin
		if (flow.load[1]) begin
			t_s2 <= t_s1;
			for (int j = 0; j < 3; j++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					prod_s2[j][a] <= prod1[j][a];
					base_s2[j][a] <= cp[j][a];
				end
			end
		end
	end

	// stage 3: level 1 points
	always_ff @(posedge clk) begin
		if (flow.load[2]) begin
			t_s3 <= t_s2;
			for (int j = 0; j < 3; j++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					lvl1_s3[j][a] <= lvl1[j][a];
				end
			end
		end
	end

	// stage 4: level 2 products
	always_ff @(posedge clk) begin
		if (flow.load[3]) begin
			t_s4 <= t_s3;
			for (int a = 0; a < NUM_AXES; a++) begin
				lvl1_s4[a] <= lvl1_s3[0][a];
				for (int j = 0; j < 2; j++) begin
					prod_s4[j][a] <= prod2[j][a];
					base_s4[j][a] <= lvl1_s3[j][a];
				end
			end
		end
	end

	// stage 5: level 2 points
	always_ff @(posedge clk) begin
		if (flow.load[4]) begin
			t_s5 <= t_s4;
			for (int a = 0; a < NUM_AXES; a++) begin
				lvl1_s5[a] <= lvl1_s4[a];
				for (int j = 0; j < 2; j++) begin
					lvl2_s5[j][a] <= lvl2[j][a];
				end
			end
		end
	end

	// stage 6: level 3 product
	always_ff @(posedge clk) begin
		if (flow.load[5]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_s6[a] <= prod3[a];
				base_s6[a] <= lvl2_s5[0][a];
				lvl1_s6[a] <= lvl1_s5[a];
				lvl2_s6[a] <= lvl2_s5[0][a];
			end
		end
	end

	// stage 7: output register
	always_ff @(posedge clk) begin
		if (flow.load[6]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				res_s7[a] <= res[a];
			end
		end
	end

	assign point.valid   = flow.vld[NUM_STAGES-1];
	assign point.point_x = res_s7[0];
	assign point.point_y = res_s7[1];
	assign point.point_z = res_s7[2];

	// an accepted beat always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(param.valid && param.ready) |=> flow.vld[0])
		else $error("accepted beat missing from first stage");

	// input back-pressure only when every stage is full and the sink stalls
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(!param.ready) |-> ((&flow.vld) && !point.ready))
		else $error("input stalled with room in the pipeline");

	// the clamped parameter never exceeds 1.0
	a_t_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		flow.vld[0] |-> (t_s1 <= T_ONE))
		else $error("curve parameter above 1.0 in stage 1");

endmodule
